/* src/assert_macros.svh */
// Assertion macros shared by the checker files of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define DWR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition is followed in the next cycle by a consequence.
`define DWR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/dwr_pkg.sv */
// Package with the shared constants of the double-ended queue.
package dwr_pkg;

  localparam int DEFAULT_DEPTH = 1024;
  localparam int DATA_W = 32;
  localparam int CMD_W = 3;
  localparam int STATUS_W = 2;
  localparam int IN_W = ((CMD_W + DATA_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ROTATE     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

/* src/dwr_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module dwr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/deque_with_half_rotate.sv */
// Top level of the bounded double-ended queue with a rotate-by-half command.
// Each command transfer yields exactly one result transfer. A push goes from acceptance
// through FIN to the result, a pop from a non-empty queue through POP_WAIT and FIN, and a
// rotate of n entries through floor(n/2) passes of ROT_RD and ROT_WR, then FIN, since it
// moves the first floor(n/2) entries to the back one at a time through the single read and
// single write port of the ring memory, with one shared modulo-DEPTH address adder forming
// every other ring position. FIN waits while the result register stays full. The input
// is not ready while a command is in progress. No clearing pass is needed after reset.
module deque_with_half_rotate #(
  parameter int DEPTH = dwr_pkg::DEFAULT_DEPTH,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int OUT_W = ((dwr_pkg::DATA_W + dwr_pkg::STATUS_W + CW + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // cmd [2:0], value [34:3], zero fill above.
  input  logic [dwr_pkg::IN_W-1:0] s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // popped_value [31:0], status [33:32], occupancy above it, zero fill above.
  output logic [OUT_W-1:0]       m_tdata
);

  import dwr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = CW + 1;

  typedef enum logic [2:0] {
    IDLE,
    POP_WAIT,
    ROT_RD,
    ROT_WR,
    FIN
  } state_t;

  state_t state;

  logic [AW-1:0]       front;
  logic [CW-1:0]       count;
  logic [CW-2:0]       steps;
  logic [AW-1:0]       waddr_hold;
  logic [DATA_W-1:0]   res_value;
  logic [STATUS_W-1:0] res_status;
  logic [DATA_W-1:0]   m_value;
  logic [STATUS_W-1:0] m_status;
  logic [CW-1:0]       m_occ;

  logic [CMD_W-1:0]    cmd;
  logic signed [DATA_W-1:0] value;
  logic                acc;
  logic                out_free;
  logic                is_full;
  logic                is_empty;
  logic [CW-1:0]       offset;
  logic [SW-1:0]       sum;
  logic [SW-1:0]       wrapped;
  logic [AW-1:0]       slot;

  logic                ram_we;
  logic                ram_re;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_raddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [DATA_W-1:0]   ram_rdata;

  assign cmd      = s_tdata[CMD_W-1:0];
  assign value    = s_tdata[CMD_W+DATA_W-1:CMD_W];
  assign s_tready = (state == IDLE);
  assign acc      = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);
  assign m_tdata  = OUT_W'({m_occ, m_status, m_value});

  // Shared ring-position adder: front plus an offset of at most DEPTH, wrapped once.
  always_comb begin
    offset = count;
    if (state == IDLE) begin
      unique case (cmd)
        CMD_PUSH_FRONT: offset = CW'(DEPTH - 1);
        CMD_PUSH_BACK:  offset = count;
        CMD_POP_FRONT:  offset = CW'(1);
        CMD_POP_BACK:   offset = count - CW'(1);
        default:        offset = count;
      endcase
    end else if (state == ROT_WR) begin
      offset = CW'(1);
    end
  end

  assign sum     = SW'(front) + SW'(offset);
  assign wrapped = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
  assign slot    = wrapped[AW-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = slot;
    ram_raddr = front;
    ram_wdata = value;
    unique case (state)
      IDLE: begin
        if (acc) begin
          if ((cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK) && !is_full) begin
            ram_we = 1'b1;
          end
          if ((cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK) && !is_empty) begin
            ram_re = 1'b1;
          end
          if (cmd == CMD_POP_BACK) begin
            ram_raddr = slot;
          end
        end
      end
      ROT_RD: begin
        ram_re = 1'b1;
      end
      ROT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = waddr_hold;
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  dwr_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      front    <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (acc) begin
            res_value  <= '0;
            res_status <= ST_OK;
            state      <= FIN;
            unique case (cmd)
              CMD_PUSH_FRONT: begin
                if (is_full) begin
                  res_status <= ST_FULL;
                end else begin
                  front <= slot;
                  count <= count + CW'(1);
                end
              end
              CMD_PUSH_BACK: begin
                if (is_full) begin
                  res_status <= ST_FULL;
                end else begin
                  count <= count + CW'(1);
                end
              end
              CMD_POP_FRONT: begin
                if (is_empty) begin
                  res_status <= ST_EMPTY;
                end else begin
                  front <= slot;
                  count <= count - CW'(1);
                  state <= POP_WAIT;
                end
              end
              CMD_POP_BACK: begin
                if (is_empty) begin
                  res_status <= ST_EMPTY;
                end else begin
                  count <= count - CW'(1);
                  state <= POP_WAIT;
                end
              end
              CMD_ROTATE: begin
                if (count > CW'(1)) begin
                  steps <= count[CW-1:1];
                  state <= ROT_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        POP_WAIT: begin
          res_value <= ram_rdata;
          state     <= FIN;
        end
        ROT_RD: begin
          // The front entry is copied to the slot just past the back.
          waddr_hold <= slot;
          state      <= ROT_WR;
        end
        ROT_WR: begin
          front <= slot;
          steps <= steps - (CW-1)'(1);
          if (steps == (CW-1)'(1)) begin
            state <= FIN;
          end else begin
            state <= ROT_RD;
          end
        end
        FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_value  <= res_value;
            m_status <= res_status;
            m_occ    <= count;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

/* src/dwr_checker.sv */
// Port-level checker for the double-ended queue and its bind to the top level.
`include "assert_macros.svh"

module dwr_checker #(
  parameter int DEPTH = dwr_pkg::DEFAULT_DEPTH,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int OUT_W = ((dwr_pkg::DATA_W + dwr_pkg::STATUS_W + CW + 7) / 8) * 8
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic [dwr_pkg::IN_W-1:0] s_tdata,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [OUT_W-1:0]         m_tdata
);

  import dwr_pkg::*;

  logic [DATA_W-1:0]   popped;
  logic [STATUS_W-1:0] status;
  logic [CW-1:0]       occ;

  assign popped = m_tdata[DATA_W-1:0];
  assign status = m_tdata[DATA_W+STATUS_W-1:DATA_W];
  assign occ    = m_tdata[DATA_W+STATUS_W+CW-1:DATA_W+STATUS_W];

  `DWR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
  `DWR_ASSERT(a_status_code, !m_tvalid || status <= ST_FULL, "undefined status code")
  `DWR_ASSERT(a_empty_result, !m_tvalid || status != ST_EMPTY || (popped == '0 && occ == '0), "empty status with data or entries")
  `DWR_ASSERT(a_full_result, !m_tvalid || status != ST_FULL || (popped == '0 && occ == CW'(DEPTH)), "full status without a full queue")
  `DWR_ASSERT(a_occ_range, !m_tvalid || occ <= CW'(DEPTH), "occupancy beyond depth")

endmodule

bind deque_with_half_rotate dwr_checker #(.DEPTH(DEPTH)) u_dwr_checker (.*);
